FILE: rtl/core/csfr_pkg.sv
// Package for the current sensor frame receiver: widths, constants, codes.
// No dependencies.
package csfr_pkg;

  localparam int WindowDepth = 8;
  localparam int WinIdxW     = $clog2(WindowDepth);
  localparam int FillW       = $clog2(WindowDepth + 1);
  localparam int AnSumW      = 24 + WinIdxW + 1;
  localparam int DgSumW      = 16 + WinIdxW + 1;

  localparam logic [7:0] CrcPoly   = 8'h1D;
  localparam logic [7:0] CrcInit   = 8'hFF;
  localparam logic [7:0] CrcXorOut = 8'hFF;
  localparam logic [7:0] StuckThrReset = 8'd5;

  // sticky error codes
  localparam logic [2:0] ErrNone     = 3'd0;
  localparam logic [2:0] ErrCrc      = 3'd1;
  localparam logic [2:0] ErrPower    = 3'd2;
  localparam logic [2:0] ErrInternal = 3'd3;
  localparam logic [2:0] ErrSafety   = 3'd4;

  localparam logic [1:0] PwrNotMeasurable = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture frame, start CRC
    logic crc_step;  // one bit of CRC
    logic commit;    // good frame: update held state, write window
    logic bad;       // bad frame: set crc error
    logic sum_clr;   // clear accumulators
    logic sum_step;  // add one window entry
    logic div_start; // start dividers
    logic div_step;  // one quotient bit
    logic avg_load;  // store averages
  } csfr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic crc_ok;
    logic sum_last;
    logic div_last;
  } csfr_sts_t;

endpackage

FILE: rtl/core/current_sensor_frame_receiver.sv
// Top level of the current sensor frame receiver.
// Depends on csfr_pkg, csfr_ctrl, csfr_datapath.
//
// Takes one 8-byte frame per input transaction and returns one result.
// A frame that fails the CRC ends after the CRC pass; one that passes also
// runs the window sum and the dividers. The CRC runs one bit per cycle over
// 56 bits, the window sum reads one entry per cycle, and the averages come
// from one-bit-per-cycle restoring dividers. One frame is in work at a time;
// a new frame is taken only once the previous result is accepted, at the
// earliest in the cycle that accepts it.
module current_sensor_frame_receiver import csfr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // byte_status, byte_analog_high, byte_analog_mid, byte_analog_low,
  // byte_digital_high, byte_digital_low, byte_spare, byte_check
  input  logic [63:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // frame_good, sequence_res, power_state, internal_fault, safety_fault,
  // analog_current, analog_average, digital_current, digital_average,
  // repeat_count, sequence_stuck, error_code, zero fill
  output logic [103:0] m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [7:0]   cfg_data_i
);

  csfr_cmd_t  cmd;
  csfr_sts_t  sts;
  logic [5:0] crc_cnt;
  logic [7:0] thr_q;

  // stuck threshold register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= StuckThrReset;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  csfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .crc_cnt_i   (crc_cnt),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  csfr_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frame_i     (s_axis_tdata),
    .stuck_thr_i (thr_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .crc_cnt_o   (crc_cnt),
    .res_o       (m_axis_tdata)
  );

endmodule

FILE: rtl/core/csfr_ctrl.sv
// Controller FSM of the current sensor frame receiver.
// Depends on csfr_pkg.
module csfr_ctrl import csfr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  logic [5:0] crc_cnt_i,
  output csfr_cmd_t cmd_o,
  input  csfr_sts_t sts_i
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StCrc   = 3'd1;
  localparam logic [2:0] StChk   = 3'd2;
  localparam logic [2:0] StSum   = 3'd3;
  localparam logic [2:0] StDiv   = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;
  localparam logic [2:0] StDivSt = 3'd6;
  localparam logic [2:0] StAvg   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;

  // accept a frame when idle and the output slot is free or draining
  assign in_ready_o  = (state_q == StIdle) && (!ovalid_q || out_ready_i);
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q;
    cmd_o    = '0;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          state_d    = StCrc;
        end
      end
      StCrc: begin
        cmd_o.crc_step = 1'b1;
        if (crc_cnt_i == 6'd55) state_d = StChk;
      end
      StChk: begin
        if (sts_i.crc_ok) begin
          cmd_o.commit  = 1'b1;
          cmd_o.sum_clr = 1'b1;
          state_d       = StSum;
        end else begin
          cmd_o.bad = 1'b1;
          state_d   = StOut;
        end
      end
      StSum: begin
        cmd_o.sum_step = 1'b1;
        if (sts_i.sum_last) state_d = StDivSt;
      end
      // sums are complete here
      StDivSt: begin
        cmd_o.div_start = 1'b1;
        state_d         = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = StAvg;
      end
      // quotients are complete here
      StAvg: begin
        cmd_o.avg_load = 1'b1;
        state_d        = StOut;
      end
      StOut: begin
        ovalid_d = 1'b1;
        state_d  = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

FILE: rtl/core/csfr_datapath.sv
// Datapath: bit-serial CRC, held state, sample windows, accumulators,
// restoring dividers. Depends on csfr_pkg.
module csfr_datapath import csfr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [63:0]  frame_i,
  input  logic [7:0]   stuck_thr_i,
  input  csfr_cmd_t    cmd_i,
  output csfr_sts_t    sts_o,
  output logic [5:0]   crc_cnt_o,
  output logic [103:0] res_o
);

  // frame and CRC
  logic [63:0] frame_q;
  logic [7:0]  crc_q;
  logic [5:0]  bit_q;
  logic        crc_fb;

  assign crc_cnt_o = bit_q;
  assign crc_fb    = crc_q[7] ^ frame_q[{bit_q[5:3], 3'd7 - bit_q[2:0]}];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
    end else if (cmd_i.load) begin
      bit_q <= '0;
    end else if (cmd_i.crc_step) begin
      bit_q <= bit_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      frame_q <= frame_i;
      crc_q   <= CrcInit;
    end else if (cmd_i.crc_step) begin
      crc_q <= {crc_q[6:0], 1'b0} ^ (crc_fb ? CrcPoly : 8'h00);
    end
  end

  assign sts_o.crc_ok = ((crc_q ^ CrcXorOut) == frame_q[63:56]);

  // held state
  logic [7:0]  status_q;
  logic [3:0]  lastseq_q;
  logic [7:0]  rep_q;
  logic [2:0]  err_q;
  logic        good_q;
  logic signed [23:0] an_q, anavg_q;
  logic signed [15:0] dg_q, dgavg_q;
  logic [WinIdxW-1:0] pos_q;
  logic [FillW-1:0]   fill_q;
  logic [3:0]  seq;
  logic [1:0]  pwr;
  logic signed [23:0] an_new;
  logic signed [15:0] dg_new;

  assign seq    = frame_q[7:4];
  assign pwr    = frame_q[3:2];
  assign an_new = {~frame_q[15], frame_q[14:8], frame_q[23:16], frame_q[31:24]};
  assign dg_new = {~frame_q[39], frame_q[38:32], frame_q[47:40]};

  // windows
  logic [23:0] an_win [WindowDepth];
  logic [15:0] dg_win [WindowDepth];
  logic [FillW-1:0] rd_q;
  logic [23:0] an_rd_q;
  logic [15:0] dg_rd_q;
  logic        rd_vld_q;
  logic signed [AnSumW-1:0] an_sum_q;
  logic signed [DgSumW-1:0] dg_sum_q;

  // divider registers
  logic [AnSumW-1:0] an_quo_q, an_rem_q;
  logic [DgSumW-1:0] dg_quo_q, dg_rem_q;
  logic an_neg_q, dg_neg_q;
  logic [5:0] dcnt_q;
  logic [AnSumW-1:0] an_mag, an_tr;
  logic [DgSumW-1:0] dg_mag, dg_tr;
  logic [AnSumW:0] an_sub;
  logic [DgSumW:0] dg_sub;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      an_win[pos_q] <= an_new;
      dg_win[pos_q] <= dg_new;
    end
    an_rd_q <= an_win[rd_q[WinIdxW-1:0]];
    dg_rd_q <= dg_win[rd_q[WinIdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q  <= '0;
      lastseq_q <= '0;
      rep_q     <= '0;
      err_q     <= ErrNone;
      good_q    <= 1'b0;
      an_q      <= '0;
      dg_q      <= '0;
      anavg_q   <= '0;
      dgavg_q   <= '0;
      pos_q     <= '0;
      fill_q    <= '0;
      rd_q      <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (cmd_i.bad) begin
        err_q  <= ErrCrc;
        good_q <= 1'b0;
      end
      if (cmd_i.commit) begin
        good_q    <= 1'b1;
        status_q  <= frame_q[7:0];
        an_q      <= an_new;
        dg_q      <= dg_new;
        if (pwr == PwrNotMeasurable) err_q <= ErrPower;
        else if (frame_q[1])         err_q <= ErrInternal;
        else if (frame_q[0])         err_q <= ErrSafety;
        pos_q  <= (pos_q == WinIdxW'(WindowDepth - 1)) ? '0 : pos_q + 1'b1;
        if (fill_q < FillW'(WindowDepth)) fill_q <= fill_q + 1'b1;
        if (seq == lastseq_q) begin
          if (rep_q != 8'hFF) rep_q <= rep_q + 8'd1;
        end else begin
          rep_q <= '0;
        end
        lastseq_q <= seq;
      end
      // read sweep: address rd_q, registered data in the next cycle
      if (cmd_i.sum_clr) begin
        rd_q     <= '0;
        rd_vld_q <= 1'b0;
      end else if (cmd_i.sum_step) begin
        rd_q     <= rd_q + 1'b1;
        rd_vld_q <= 1'b1;
      end
      if (cmd_i.avg_load) begin
        anavg_q <= an_neg_q ? -an_quo_q[23:0] : an_quo_q[23:0];
        dgavg_q <= dg_neg_q ? -dg_quo_q[15:0] : dg_quo_q[15:0];
      end
    end
  end

  // last summing cycle: data for entry fill-1 arrives
  assign sts_o.sum_last = rd_vld_q && (rd_q == fill_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_clr) begin
      an_sum_q <= '0;
      dg_sum_q <= '0;
    end else if (cmd_i.sum_step && rd_vld_q) begin
      an_sum_q <= an_sum_q + AnSumW'(signed'(an_rd_q));
      dg_sum_q <= dg_sum_q + DgSumW'(signed'(dg_rd_q));
    end
  end

  // restoring dividers on magnitudes, shared bit counter
  assign an_mag = an_sum_q[AnSumW-1] ? AnSumW'(-an_sum_q) : an_sum_q;
  assign dg_mag = dg_sum_q[DgSumW-1] ? DgSumW'(-dg_sum_q) : dg_sum_q;
  assign an_tr  = {an_rem_q[AnSumW-2:0], an_quo_q[AnSumW-1]};
  assign dg_tr  = {dg_rem_q[DgSumW-2:0], dg_quo_q[DgSumW-1]};
  assign an_sub = {1'b0, an_tr} - (AnSumW+1)'(fill_q);
  assign dg_sub = {1'b0, dg_tr} - (DgSumW+1)'(fill_q);
  assign sts_o.div_last = (dcnt_q == 6'(AnSumW - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      an_quo_q <= an_mag;
      dg_quo_q <= dg_mag;
      an_rem_q <= '0;
      dg_rem_q <= '0;
      an_neg_q <= an_sum_q[AnSumW-1];
      dg_neg_q <= dg_sum_q[DgSumW-1];
      dcnt_q   <= '0;
    end else if (cmd_i.div_step) begin
      dcnt_q   <= dcnt_q + 6'd1;
      an_rem_q <= an_sub[AnSumW] ? an_tr : an_sub[AnSumW-1:0];
      an_quo_q <= {an_quo_q[AnSumW-2:0], ~an_sub[AnSumW]};
      // the shorter divider is finished and holds once its bits are done
      if (dcnt_q < 6'(DgSumW)) begin
        dg_rem_q <= dg_sub[DgSumW] ? dg_tr : dg_sub[DgSumW-1:0];
        dg_quo_q <= {dg_quo_q[DgSumW-2:0], ~dg_sub[DgSumW]};
      end
    end
  end

  // result packing, field order of the output item
  assign res_o = {3'd0, err_q, (rep_q >= stuck_thr_i), rep_q,
                  dgavg_q, dg_q, anavg_q, an_q,
                  status_q[0], status_q[1], status_q[3:2], status_q[7:4], good_q};

endmodule

FILE: rtl/core/csfr_checker.sv
// Port-level checker for the current sensor frame receiver, bound to the top.
// Depends on the top level's ports only.
module csfr_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata
);

  // held result stays while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // an accepted frame is not ready again next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready right after accept");

  // a frame accepted while no result is pending shows no result at one check point within its CRC pass
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##8 !m_axis_tvalid)
    else $error("result too early");

  // error code stays in range
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[100:98] <= 3'd4)
    else $error("error code out of range");

endmodule

bind current_sensor_frame_receiver csfr_checker u_csfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
